@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ sv/sacl_pkg.sv @@
// Package of shared types and constants for the cache tag controller.
package sacl_pkg;
  localparam int unsigned BlockBytesDef = 64;
  localparam int unsigned SetsDef = 64;
  localparam int unsigned WaysDef = 4;
  localparam int unsigned AddrBits = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CmdFill = 2'd0,
    CmdWriteback = 2'd1,
    CmdWrite = 2'd2,
    CmdResp = 2'd3
  } cmd_kind_e;

  typedef enum logic {
    CfgWriteThrough = 1'b0,
    CfgWriteAllocate = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StProbe,
    StFill,
    StWback,
    StWrite,
    StResp
  } back_state_e;

  typedef struct packed {
    logic [31:0] address;
    logic        is_read;
    logic [3:0]  access_bytes;
  } access_t;

  typedef struct packed {
    logic [1:0]  command_kind;
    logic [31:0] lower_address;
    logic [6:0]  lower_bytes;
    logic        hit;
    logic [1:0]  way;
    logic [31:0] access_total;
    logic [31:0] miss_total;
    logic        last_result;
  } result_t;
endpackage

@@ sv/set_assoc_cache_controller_lru_core.sv @@
// Top level of the set-associative cache tag controller with LRU replacement.
//  channel  | handshake         | words
//  access   | push / full       | address_i, is_read_i, access_bytes_i
//  result   | pop / empty       | command_kind_o .. last_result_o
//  config   | cfg_we_i          | cfg_index_i, cfg_data_i
// Once an access heads the access queue it passes these steps in order: take, set read,
// hit and victim resolve, the fill step (carrying the fill command on an allocating
// miss), a step for each further lower command and one for the response.
// Reset clears the valid bits and counters at once; tags, ranks and dirty marks are
// only read for valid ways, so no clearing pass is needed.
// While the two-word output queue is full the back end holds its word; the two-word
// access queue then fills and raises full.
module set_assoc_cache_controller_lru_core #(
  parameter int unsigned BLOCK_BYTES = sacl_pkg::BlockBytesDef,
  parameter int unsigned SETS = sacl_pkg::SetsDef,
  parameter int unsigned WAYS = sacl_pkg::WaysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] address_i,
  input  logic        is_read_i,
  input  logic [3:0]  access_bytes_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  command_kind_o,
  output logic [31:0] lower_address_o,
  output logic [6:0]  lower_bytes_o,
  output logic        hit_o,
  output logic [1:0]  way_o,
  output logic [31:0] access_total_o,
  output logic [31:0] miss_total_o,
  output logic        last_result_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i
);
  sacl_pkg::access_t in_w, head_w;
  sacl_pkg::result_t res_w;
  logic avail_w, take_w, rvalid_w;
  logic wt_q, wa_q;
  sacl_pkg::result_t oq_q [2];
  logic orp_q, owp_q;
  logic [1:0] ocnt_q;
  logic oful_w;

  assign in_w = '{address: address_i, is_read: is_read_i, access_bytes: access_bytes_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q <= 1'b0;
      wa_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == sacl_pkg::CfgWriteThrough) wt_q <= cfg_data_i;
      else wa_q <= cfg_data_i;
    end
  end

  sacl_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_i(in_w),
    .avail_o(avail_w), .head_o(head_w), .take_i(take_w)
  );

  sacl_back #(.BLOCK_BYTES(BLOCK_BYTES), .SETS(SETS), .WAYS(WAYS)) u_back (
    .clk_i, .rst_ni, .avail_i(avail_w), .acc_i(head_w), .take_o(take_w),
    .write_through_i(wt_q), .write_allocate_i(wa_q),
    .valid_o(rvalid_w), .res_o(res_w), .ready_i(!oful_w)
  );

  // Output queue of two words.
  assign oful_w = ocnt_q == 2'd2;
  assign empty = ocnt_q == 2'd0;
  always_ff @(posedge clk_i) if (rvalid_w && !oful_w) oq_q[owp_q] <= res_w;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orp_q <= 1'b0; owp_q <= 1'b0; ocnt_q <= 2'd0;
    end else begin
      if (rvalid_w && !oful_w) owp_q <= ~owp_q;
      if (pop && !empty) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + 2'(rvalid_w && !oful_w) - 2'(pop && !empty);
    end
  end
  assign command_kind_o = oq_q[orp_q].command_kind;
  assign lower_address_o = oq_q[orp_q].lower_address;
  assign lower_bytes_o = oq_q[orp_q].lower_bytes;
  assign hit_o = oq_q[orp_q].hit;
  assign way_o = oq_q[orp_q].way;
  assign access_total_o = oq_q[orp_q].access_total;
  assign miss_total_o = oq_q[orp_q].miss_total;
  assign last_result_o = oq_q[orp_q].last_result;
endmodule

@@ sv/sacl_front.sv @@
// Front end: takes accesses into a short queue for the back end.
module sacl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sacl_pkg::access_t in_i,
  output logic              avail_o,
  output sacl_pkg::access_t head_o,
  input  logic              take_i
);
  localparam int unsigned D = sacl_pkg::QueueDepth;
  sacl_pkg::access_t mem_q [D];
  logic rp_q, wp_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign full = (cnt_q == 2'(D));
  assign avail_o = (cnt_q != 2'd0);
  assign head_o = mem_q[rp_q];
  assign do_push = push && !full;
  assign do_pop = take_i && avail_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0;
      wp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, cnt_q > 2'(D))
  `ASSERT_IMPL(a_pop_drops, clk_i, rst_ni, (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 2'd1)
  `ASSERT_IMPL(a_push_grows, clk_i, rst_ni, (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1)
endmodule

@@ sv/sacl_back.sv @@
// Back end: tag lookup, LRU update and command sequencing.
module sacl_back #(
  parameter int unsigned BLOCK_BYTES = sacl_pkg::BlockBytesDef,
  parameter int unsigned SETS = sacl_pkg::SetsDef,
  parameter int unsigned WAYS = sacl_pkg::WaysDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  sacl_pkg::access_t acc_i,
  output logic              take_o,
  input  logic              write_through_i,
  input  logic              write_allocate_i,
  output logic              valid_o,
  output sacl_pkg::result_t res_o,
  input  logic              ready_i
);
  localparam int unsigned OB = $clog2(BLOCK_BYTES);
  localparam int unsigned SB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SBR = $clog2(SETS);
  localparam int unsigned TB = 32 - OB - SBR;
  localparam int unsigned WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RB = (WAYS > 1) ? $clog2(WAYS) : 1;

  // One word per set holds all of its ways; tags, ranks and dirty marks are
  // only looked at for valid ways, so they need no reset.
  logic [WAYS-1:0][TB-1:0] tag_mem [SETS];
  logic [WAYS-1:0][RB-1:0] rank_mem [SETS];
  logic [WAYS-1:0] dirty_mem [SETS];
  logic [WAYS-1:0] valid_q [SETS];
  logic [31:0] acc_cnt_q, miss_cnt_q;

  sacl_pkg::back_state_e st_q, st_d;
  sacl_pkg::access_t cur_q;
  logic [WAYS-1:0][TB-1:0] rtag_q;
  logic [WAYS-1:0][RB-1:0] rrank_q;
  logic [WAYS-1:0] rdirty_q, rvalid_q;
  logic hit_q;
  logic [WB-1:0] way_q;

  logic [31:0] setf_w;
  logic [SB-1:0] set_w;
  logic [TB-1:0] tag_w;
  logic [WB-1:0] hway_w, vic_w;
  logic hit_w, alloc_w, wb_w, emit, upd;
  logic [RB-1:0] top_w;
  logic [31:0] kick_w;
  logic [WAYS-1:0][RB-1:0] nrank_w;
  logic [WAYS-1:0] nvalid_w, ndirty_w;
  logic [WAYS-1:0][TB-1:0] ntag_w;

  // The index field is below twice SETS, so one subtraction reduces it.
  assign setf_w = (cur_q.address >> OB) & ((32'd1 << SBR) - 32'd1);
  assign set_w = SB'((setf_w >= SETS) ? setf_w - SETS : setf_w);
  assign tag_w = TB'(cur_q.address >> (OB + SBR));

  always_comb begin
    hit_w = 1'b0;
    hway_w = '0;
    vic_w = '0;
    top_w = rrank_q[0];
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rvalid_q[i] && (rtag_q[i] == tag_w)) begin
        hit_w = 1'b1;
        hway_w = WB'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (rrank_q[i] > top_w) begin
        top_w = rrank_q[i];
        vic_w = WB'(i);
      end
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!rvalid_q[i]) vic_w = WB'(i);
    end
  end

  assign alloc_w = cur_q.is_read || write_allocate_i;
  assign wb_w = !write_through_i && rvalid_q[way_q] && rdirty_q[way_q];
  assign kick_w = (32'(rtag_q[way_q]) << (OB + SBR)) | (32'(set_w) << OB);

  // New contents of the set word: the chosen way becomes most recent.
  always_comb begin
    nrank_w = rrank_q;
    for (int i = 0; i < WAYS; i++) begin
      if (WB'(i) != way_q && rvalid_q[i] &&
          (!rvalid_q[way_q] || rrank_q[i] < rrank_q[way_q]) &&
          rrank_q[i] < RB'(WAYS - 1))
        nrank_w[i] = rrank_q[i] + RB'(1);
    end
    nrank_w[way_q] = '0;
    nvalid_w = rvalid_q;
    nvalid_w[way_q] = 1'b1;
    ndirty_w = rdirty_q;
    if (hit_q) begin
      if (!cur_q.is_read) ndirty_w[way_q] = !write_through_i;
    end else begin
      ndirty_w[way_q] = !cur_q.is_read && !write_through_i;
    end
    ntag_w = rtag_q;
    ntag_w[way_q] = tag_w;
  end

  assign emit = valid_o && ready_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sacl_pkg::StIdle: if (avail_i) st_d = sacl_pkg::StRead;
      sacl_pkg::StRead: st_d = sacl_pkg::StProbe;
      sacl_pkg::StProbe: st_d = sacl_pkg::StFill;
      sacl_pkg::StFill: begin
        if (hit_q) st_d = (!cur_q.is_read && write_through_i) ? sacl_pkg::StWrite
                                                              : sacl_pkg::StResp;
        else if (!alloc_w) st_d = sacl_pkg::StWrite;
        else if (emit) st_d = wb_w ? sacl_pkg::StWback
                 : ((!cur_q.is_read && write_through_i) ? sacl_pkg::StWrite : sacl_pkg::StResp);
      end
      sacl_pkg::StWback: if (emit) st_d = (!cur_q.is_read && write_through_i)
                                          ? sacl_pkg::StWrite : sacl_pkg::StResp;
      sacl_pkg::StWrite: if (emit) st_d = sacl_pkg::StResp;
      sacl_pkg::StResp: if (emit) st_d = sacl_pkg::StIdle;
      default: st_d = sacl_pkg::StIdle;
    endcase
  end

  always_comb begin
    take_o = (st_q == sacl_pkg::StIdle) && avail_i;
    valid_o = 1'b0;
    res_o = '0;
    unique case (st_q)
      sacl_pkg::StFill: begin
        valid_o = !hit_q && alloc_w;
        res_o.command_kind = sacl_pkg::CmdFill;
        res_o.lower_address = cur_q.address & ~32'((1 << OB) - 1);
        res_o.lower_bytes = 7'(BLOCK_BYTES);
      end
      sacl_pkg::StWback: begin
        valid_o = 1'b1;
        res_o.command_kind = sacl_pkg::CmdWriteback;
        res_o.lower_address = kick_w;
        res_o.lower_bytes = 7'(BLOCK_BYTES);
      end
      sacl_pkg::StWrite: begin
        valid_o = 1'b1;
        res_o.command_kind = sacl_pkg::CmdWrite;
        res_o.lower_address = cur_q.address;
        res_o.lower_bytes = 7'(cur_q.access_bytes);
      end
      sacl_pkg::StResp: begin
        valid_o = 1'b1;
        res_o.command_kind = sacl_pkg::CmdResp;
        res_o.hit = hit_q;
        res_o.way = 2'(way_q);
        res_o.access_total = acc_cnt_q;
        res_o.miss_total = miss_cnt_q;
        res_o.last_result = 1'b1;
      end
      default: ;
    endcase
  end

  // Update of the line state, on a hit or an allocating miss, happens on leaving the fill step.
  assign upd = (st_q == sacl_pkg::StFill) && (st_d != sacl_pkg::StFill) &&
               (hit_q || alloc_w);

  always_ff @(posedge clk_i) begin
    if (st_q == sacl_pkg::StIdle && avail_i) cur_q <= acc_i;
    if (st_q == sacl_pkg::StRead) begin
      rtag_q <= tag_mem[set_w];
      rrank_q <= rank_mem[set_w];
      rdirty_q <= dirty_mem[set_w];
    end
    if (upd) begin
      tag_mem[set_w] <= ntag_w;
      rank_mem[set_w] <= nrank_w;
      dirty_mem[set_w] <= ndirty_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sacl_pkg::StIdle;
      for (int i = 0; i < SETS; i++) valid_q[i] <= '0;
      rvalid_q <= '0;
      acc_cnt_q <= '0;
      miss_cnt_q <= '0;
      hit_q <= 1'b0;
      way_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == sacl_pkg::StRead) begin
        acc_cnt_q <= acc_cnt_q + 32'd1;
        rvalid_q <= valid_q[set_w];
      end
      // The set word is registered; hit and victim are settled here.
      if (st_q == sacl_pkg::StProbe) begin
        hit_q <= hit_w;
        way_q <= hit_w ? hway_w : vic_w;
        if (!hit_w) miss_cnt_q <= miss_cnt_q + 32'd1;
      end
      if (upd) valid_q[set_w] <= nvalid_w;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_resp_last, clk_i, rst_ni, (valid_o && res_o.last_result) |-> st_q == sacl_pkg::StResp)
  `ASSERT_NEVER(a_take_busy, clk_i, rst_ni, take_o && st_q != sacl_pkg::StIdle)
  `ASSERT_IMPL(a_resp_hold, clk_i, rst_ni, (st_q == sacl_pkg::StResp && !ready_i) |=> st_q == sacl_pkg::StResp)
endmodule

@@ sim/tb_set_assoc_cache_controller_lru_core.sv @@
// Self-checking testbench for the set-associative cache tag controller with LRU replacement.
module tb_set_assoc_cache_controller_lru_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BlkBytes = 64;
  localparam int unsigned NumSets = 64;
  localparam int unsigned NumWays = 4;
  localparam int unsigned OffBits = 6;
  localparam int unsigned SetBits = 6;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] address_i = '0;
  logic        is_read_i = 1'b0;
  logic [3:0]  access_bytes_i = 4'd1;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  command_kind_o;
  logic [31:0] lower_address_o;
  logic [6:0]  lower_bytes_o;
  logic        hit_o;
  logic [1:0]  way_o;
  logic [31:0] access_total_o;
  logic [31:0] miss_total_o;
  logic        last_result_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic        cfg_data_i = 1'b0;

  set_assoc_cache_controller_lru_core dut (.*);

  // The clock toggles every half period of 10 ns.
  always #10 clk_i = ~clk_i;

  // Shadow copy of the tag side of the cache. Ranks count up from zero for
  // the most recently used valid way of each set.
  logic [19:0] shadow_tag  [NumSets*NumWays];
  logic        shadow_valid[NumSets*NumWays];
  logic        shadow_dirty[NumSets*NumWays];
  logic [1:0]  shadow_rank [NumSets*NumWays];
  logic [31:0] shadow_accesses;
  logic [31:0] shadow_misses;
  logic        mode_write_through;
  logic        mode_write_allocate;

  sacl_pkg::result_t pending_words[$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned hold_off_cycles = 0;

  // Prints one line per mismatch and keeps the tally.
  task automatic report(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Marks way w of the set starting at base as most recently used. Ways that
  // were more recent than it age by one; a way filled from invalid ages all.
  function automatic void make_recent(input int base, input int w);
    logic [1:0] old_rank;
    bit         was_valid;
    old_rank  = shadow_rank[base+w];
    was_valid = shadow_valid[base+w];
    for (int i = 0; i < NumWays; i++) begin
      if (i != w && shadow_valid[base+i] &&
          (!was_valid || shadow_rank[base+i] < old_rank) &&
          shadow_rank[base+i] < NumWays - 1)
        shadow_rank[base+i]++;
    end
    shadow_rank[base+w] = 2'd0;
  endfunction

  function automatic int choose_victim(input int base);
    int         best;
    logic [1:0] top;
    best = 0;
    top  = shadow_rank[base];
    for (int i = 0; i < NumWays; i++) begin
      if (!shadow_valid[base+i]) return i;
      if (shadow_rank[base+i] > top) begin
        top  = shadow_rank[base+i];
        best = i;
      end
    end
    return best;
  endfunction

  function automatic sacl_pkg::result_t lower_word(input sacl_pkg::cmd_kind_e kind,
                                                   input logic [31:0] addr,
                                                   input logic [6:0] nbytes);
    sacl_pkg::result_t r;
    r = '0;
    r.command_kind  = kind;
    r.lower_address = addr;
    r.lower_bytes   = nbytes;
    return r;
  endfunction

  // Works out every word that one access produces and queues them in order.
  function automatic void predict_access(input logic [31:0] addr, input logic rd,
                                         input logic [3:0] nb);
    int                set_idx;
    int                base;
    int                w;
    bit                hit;
    logic [19:0]       tag;
    logic [31:0]       victim_addr;
    sacl_pkg::result_t r;
    set_idx = addr[OffBits +: SetBits];
    tag     = addr[31:OffBits+SetBits];
    base    = set_idx * NumWays;
    w       = 0;
    hit     = 1'b0;
    shadow_accesses++;
    for (int i = 0; i < NumWays; i++) begin
      if (!hit && shadow_valid[base+i] && shadow_tag[base+i] == tag) begin
        w   = i;
        hit = 1'b1;
      end
    end
    if (hit) begin
      make_recent(base, w);
      if (!rd) begin
        if (mode_write_through) begin
          pending_words.push_back(lower_word(sacl_pkg::CmdWrite, addr, {3'b0, nb}));
          shadow_dirty[base+w] = 1'b0;
        end else begin
          shadow_dirty[base+w] = 1'b1;
        end
      end
    end else begin
      shadow_misses++;
      w = choose_victim(base);
      if (rd || mode_write_allocate) begin
        pending_words.push_back(lower_word(sacl_pkg::CmdFill, {addr[31:OffBits], 6'b0},
                                           7'(BlkBytes)));
        if (!mode_write_through && shadow_valid[base+w] && shadow_dirty[base+w]) begin
          victim_addr = {shadow_tag[base+w], set_idx[SetBits-1:0], 6'b0};
          pending_words.push_back(lower_word(sacl_pkg::CmdWriteback, victim_addr,
                                             7'(BlkBytes)));
        end
        make_recent(base, w);
        shadow_tag[base+w]   = tag;
        shadow_valid[base+w] = 1'b1;
        shadow_dirty[base+w] = !rd && !mode_write_through;
        if (!rd && mode_write_through)
          pending_words.push_back(lower_word(sacl_pkg::CmdWrite, addr, {3'b0, nb}));
      end else begin
        pending_words.push_back(lower_word(sacl_pkg::CmdWrite, addr, {3'b0, nb}));
      end
    end
    r = '0;
    r.command_kind = sacl_pkg::CmdResp;
    r.hit          = hit;
    r.way          = 2'(w);
    r.access_total = shadow_accesses;
    r.miss_total   = shadow_misses;
    r.last_result  = 1'b1;
    pending_words.push_back(r);
  endfunction

  // Offers one access until the block takes it, with optional idle cycles
  // in front; the shadow model is updated at the accepting edge. Push stays
  // high afterwards so that the next access can follow straight on.
  task automatic send_access(input logic [31:0] addr, input logic rd, input logic [3:0] nb);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push           <= 1'b1;
    address_i      <= addr;
    is_read_i      <= rd;
    access_bytes_i <= nb;
    do @(posedge clk_i); while (full);
    predict_access(addr, rd, nb);
  endtask

  // Stops offering, waits for every queued word to drain, then lets the
  // back end settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(input sacl_pkg::cfg_index_e idx, input logic value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (idx == sacl_pkg::CfgWriteThrough) mode_write_through = value;
    else mode_write_allocate = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] make_addr(input int tag, input int set_idx, input int off);
    return {20'(tag), 6'(set_idx), 6'(off)};
  endfunction

  // Random access biased towards a small pool of tags so that sets fill,
  // hit and evict; a share of fully random addresses adds noise.
  task automatic random_access();
    logic [31:0] addr;
    if ($urandom_range(0, 9) == 0) addr = $urandom;
    else addr = make_addr($urandom_range(0, 6) << ($urandom_range(0, 1) * 13),
                          $urandom_range(0, 7), $urandom_range(0, 63));
    send_access(addr, 1'($urandom), ($urandom_range(0, 7) == 0) ? 4'($urandom)
                                                                : 4'($urandom_range(1, 8)));
  endtask

  // Directed: field extremes, hits, LRU eviction with a dirty victim,
  // write-around and write-through behaviour, odd byte counts.
  task automatic test_directed();
    send_access(32'h0000_0000, 1'b1, 4'd1);
    send_access(32'hFFFF_FFFF, 1'b0, 4'd8);
    send_access(32'h0000_0007, 1'b0, 4'd15);
    send_access(32'hFFFF_FFC0, 1'b1, 4'd0);
    for (int t = 1; t <= 5; t++) send_access(make_addr(t, 3, 0), t[0], 4'd4);
    send_access(make_addr(2, 3, 60), 1'b1, 4'd8);
    send_access(make_addr(9, 3, 0), 1'b0, 4'd2);
    send_access(make_addr(10, 3, 0), 1'b1, 4'd2);
    wait_drained();
    write_mode(sacl_pkg::CfgWriteAllocate, 1'b0);
    send_access(make_addr(11, 5, 1), 1'b0, 4'd3);
    send_access(make_addr(11, 5, 1), 1'b1, 4'd3);
    send_access(make_addr(11, 5, 9), 1'b0, 4'd5);
    wait_drained();
    write_mode(sacl_pkg::CfgWriteThrough, 1'b1);
    send_access(make_addr(12, 5, 0), 1'b0, 4'd8);
    send_access(make_addr(11, 5, 0), 1'b0, 4'd1);
    for (int t = 20; t <= 23; t++) send_access(make_addr(t, 3, 0), 1'b1, 4'd1);
    wait_drained();
  endtask

  task automatic test_random_modes();
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(sacl_pkg::CfgWriteThrough, phase[0]);
      write_mode(sacl_pkg::CfgWriteAllocate, phase[1]);
      repeat (65) random_access();
      wait_drained();
    end
  endtask

  // The receiver stops popping for a long stretch while accesses keep
  // coming, so the output queue and then the access queue fill up.
  task automatic test_backpressure();
    write_mode(sacl_pkg::CfgWriteThrough, 1'b0);
    write_mode(sacl_pkg::CfgWriteAllocate, 1'b1);
    hold_off_cycles = 60;
    repeat (30) random_access();
    wait_drained();
  endtask

  // Last part of the run: no idling on either side.
  task automatic test_full_rate();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    repeat (60) random_access();
    wait_drained();
  endtask

  // Drives pop with idle bursts, and a long hold-off on request.
  initial begin
    int idle;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        pop <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      if (receiver_idles && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        idle = $urandom_range(1, 3);
        repeat (idle - 1) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compares each word the block hands over with the oldest prediction.
  always @(posedge clk_i) begin
    sacl_pkg::result_t seen;
    sacl_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      seen = '{command_kind_o, lower_address_o, lower_bytes_o, hit_o, way_o,
               access_total_o, miss_total_o, last_result_o};
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %p", seen));
      end else begin
        want = pending_words.pop_front();
        if (seen.command_kind != want.command_kind)
          report($sformatf("kind %0d, want %0d", seen.command_kind, want.command_kind));
        if (seen.lower_address != want.lower_address)
          report($sformatf("address %h, want %h", seen.lower_address, want.lower_address));
        if (seen.lower_bytes != want.lower_bytes)
          report($sformatf("bytes %0d, want %0d", seen.lower_bytes, want.lower_bytes));
        if (seen.hit != want.hit)
          report($sformatf("hit %0b, want %0b", seen.hit, want.hit));
        if (seen.way != want.way)
          report($sformatf("way %0d, want %0d", seen.way, want.way));
        if (seen.access_total != want.access_total)
          report($sformatf("accesses %0d, want %0d", seen.access_total, want.access_total));
        if (seen.miss_total != want.miss_total)
          report($sformatf("misses %0d, want %0d", seen.miss_total, want.miss_total));
        if (seen.last_result != want.last_result)
          report($sformatf("last %0b, want %0b", seen.last_result, want.last_result));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumSets*NumWays; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i]  = '0;
    end
    shadow_accesses     = '0;
    shadow_misses       = '0;
    mode_write_through  = 1'b0;
    mode_write_allocate = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_modes();
    test_backpressure();
    test_full_rate();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
